### hdl/fbab_pkg.sv
package fbab_pkg;
    localparam int MaxWidth  = 128;
    localparam int MaxHeight = 128;
    localparam int XW = $clog2(MaxWidth);
    localparam int YW = $clog2(MaxHeight);
    localparam int AW = XW + YW;
    localparam int Depth = MaxWidth * MaxHeight;
    localparam int DW = 8;
    localparam int CW = 11;

    localparam logic [1:0] FUNC_BLEND   = 2'd0;
    localparam logic [1:0] FUNC_READ    = 2'd1;
    localparam logic [1:0] FUNC_FILL    = 2'd2;
    localparam logic [1:0] FUNC_PATTERN = 2'd3;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // command from sequencer to the shared divide unit
    typedef struct packed {
        logic        start;
        logic [17:0] num;
        logic [7:0]  den;
    } div_req_t;

    typedef struct packed {
        logic       done;
        logic [9:0] quo;
    } div_rsp_t;
endpackage

### hdl/framebuffer_alpha_blend_engine_unit.sv
// a read steps RD, RDW, OUT; a blend RD, RDW, MIX for each channel, MIXW, OUT; outside
// the frame goes straight to OUT; fill writes one pixel a cycle; pattern takes two divides
// a pixel on the shared bit-serial divider that forms both ramps; empty frame goes to OUT
// the result sits in its own output register; the next word is taken the cycle after
// it loads, so no new word is taken while the last one is still in progress
// after reset the store is swept to zero with in_stall high; rst_n clears
// control state and the frame size registers
module framebuffer_alpha_blend_engine_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic signed [10:0] pos_x,
    input  logic signed [10:0] pos_y,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic [7:0]  coverage,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_red,
    output logic [7:0]  out_green,
    output logic [7:0]  out_blue,
    output logic [7:0]  out_alpha,
    output logic        in_range
);
    import fbab_pkg::*;

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_RD    = 4'd2;
    localparam logic [3:0] ST_RDW   = 4'd3;
    localparam logic [3:0] ST_MIX   = 4'd4;
    localparam logic [3:0] ST_FILL  = 4'd5;
    localparam logic [3:0] ST_PDX   = 4'd6;
    localparam logic [3:0] ST_PDY   = 4'd7;
    localparam logic [3:0] ST_PWR   = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;
    localparam logic [3:0] ST_MIXW  = 4'd10;

    logic [3:0]  state_reg, state_next;
    logic [7:0]  fw_reg, fh_reg;
    logic [7:0]  ew, eh;
    logic [1:0]  func_reg, func_next;
    logic [XW-1:0] x_reg, x_next;
    logic [YW-1:0] y_reg, y_next;
    logic [7:0]  c_reg [3];
    logic [7:0]  cov_reg;
    logic [7:0]  rx_reg, rx_next;
    logic [1:0]  ch_reg, ch_next;
    logic [31:0] pix_reg, pix_next;
    logic [AW:0] clr_reg, clr_next;
    logic [31:0] res_reg, res_next;
    logic        hit_reg, hit_next;
    logic [31:0] ores_reg;
    logic        ohit_reg;
    logic        ov_reg, ov_next;
    logic        mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [31:0] mem_wd, mem_rd;
    logic        accept, in_frame;
    logic [7:0]  lastx, lasty;
    logic [7:0]  old_c, cc;
    logic [16:0] mix_sum;
    logic [7:0]  mix_q;
    div_req_t    dreq;
    div_rsp_t    drsp;

    // effective frame, clamped to the store size
    assign ew = (fw_reg > 8'(MaxWidth))  ? 8'(MaxWidth)  : fw_reg;
    assign eh = (fh_reg > 8'(MaxHeight)) ? 8'(MaxHeight) : fh_reg;
    assign lastx = (ew > 8'd1) ? ew - 8'd1 : 8'd1;
    assign lasty = (eh > 8'd1) ? eh - 8'd1 : 8'd1;

    assign accept = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign in_frame = !pos_x[10] && !pos_y[10] && (pos_x < $signed({3'b0, ew}))
        && (pos_y < $signed({3'b0, eh}));

    // blend of one channel: divide by 255 via (s + 1 + (s >> 8)) >> 8
    assign old_c = pix_reg[8*ch_reg +: 8];
    assign cc = c_reg[ch_reg];
    always_comb
    begin
        logic [16:0] s;
        s = 17'(cc) * 17'(cov_reg) + 17'(old_c) * 17'(8'd255 - cov_reg) + 17'd127;
        mix_sum = s;
        mix_q = 8'((s + 17'd1 + (s >> 8)) >> 8);
    end

    always_comb
    begin
        state_next = state_reg;
        func_next  = func_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        rx_next    = rx_reg;
        ch_next    = ch_reg;
        pix_next   = pix_reg;
        clr_next   = clr_reg;
        res_next   = res_reg;
        hit_next   = hit_reg;
        ov_next    = ov_reg;
        mem_we     = 1'b0;
        mem_wa     = {y_reg, x_reg};
        mem_wd     = '0;
        mem_ra     = {y_reg, x_reg};
        dreq       = '0;
        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
                mem_wa = clr_reg[AW-1:0];
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (AW+1)'(Depth - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    func_next = func;
                    x_next = pos_x[XW-1:0];
                    y_next = pos_y[YW-1:0];
                    res_next = '0;
                    hit_next = 1'b0;
                    ch_next = '0;
                    case (func)
                        FUNC_BLEND, FUNC_READ:
                        begin
                            hit_next = in_frame;
                            state_next = in_frame ? ST_RD : ST_OUT;
                        end
                        default:
                        begin
                            x_next = '0;
                            y_next = '0;
                            if (ew == 8'd0 || eh == 8'd0)
                            begin
                                state_next = ST_OUT;
                            end
                            else if (func == FUNC_FILL)
                            begin
                                state_next = ST_FILL;
                            end
                            else
                            begin
                                state_next = ST_PDX;
                                dreq.start = 1'b1;
                                dreq.num = '0;
                                dreq.den = lastx;
                            end
                        end
                    endcase
                end
            end
            ST_RD:
            begin
                state_next = ST_RDW;
            end
            ST_RDW:
            begin
                pix_next = mem_rd;
                if (func_reg == FUNC_READ)
                begin
                    res_next = mem_rd;
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_MIX;
                end
            end
            ST_MIX:
            begin
                pix_next[8*ch_reg +: 8] = mix_q;
                if (ch_reg == 2'd2)
                begin
                    state_next = ST_MIXW;
                end
                else
                begin
                    ch_next = ch_reg + 2'd1;
                end
            end
            ST_MIXW:
            begin
                mem_we = 1'b1;
                mem_wd = pix_reg;
                state_next = ST_OUT;
            end
            ST_FILL:
            begin
                mem_we = 1'b1;
                mem_wd = {8'd255, c_reg[2], c_reg[1], c_reg[0]};
                if ({1'b0, x_reg} == (XW+1)'(ew - 8'd1))
                begin
                    x_next = '0;
                    if ({1'b0, y_reg} == (YW+1)'(eh - 8'd1))
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        y_next = y_reg + 1'b1;
                    end
                end
                else
                begin
                    x_next = x_reg + 1'b1;
                end
            end
            ST_PDX:
            begin
                if (drsp.done)
                begin
                    rx_next = drsp.quo[7:0];
                    dreq.start = 1'b1;
                    dreq.num = 18'(y_reg) * 18'd255;
                    dreq.den = lasty;
                    state_next = ST_PDY;
                end
            end
            ST_PDY:
            begin
                if (drsp.done)
                begin
                    mem_we = 1'b1;
                    mem_wd = {8'd255,
                        ((x_reg[XW-1:5] + y_reg[YW-1:5]) & 1'b1) == 0 ? 8'd200 : 8'd40,
                        drsp.quo[7:0], rx_reg};
                    state_next = ST_PWR;
                end
            end
            ST_PWR:
            begin
                state_next = ST_PDX;
                if ({1'b0, x_reg} == (XW+1)'(ew - 8'd1))
                begin
                    x_next = '0;
                    if ({1'b0, y_reg} == (YW+1)'(eh - 8'd1))
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        y_next = y_reg + 1'b1;
                    end
                end
                else
                begin
                    x_next = x_reg + 1'b1;
                end
                if (state_next == ST_PDX)
                begin
                    dreq.start = 1'b1;
                    dreq.num = 18'(x_next) * 18'd255;
                    dreq.den = lastx;
                end
            end
            ST_OUT:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            ov_reg    <= 1'b0;
            fw_reg    <= '0;
            fh_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            ov_reg    <= ov_next;
            if (cfg_we && cfg_index == REG_WIDTH)
            begin
                fw_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == REG_HEIGHT)
            begin
                fh_reg <= cfg_data;
            end
        end
    end

    // payload, only loaded under the sequencer
    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        rx_reg   <= rx_next;
        ch_reg   <= ch_next;
        pix_reg  <= pix_next;
        res_reg  <= res_next;
        hit_reg  <= hit_next;
        if (state_reg == ST_IDLE && accept)
        begin
            c_reg[0] <= red;
            c_reg[1] <= green;
            c_reg[2] <= blue;
            cov_reg  <= coverage;
        end
        // output register, holds while the receiver stalls
        if (state_reg == ST_OUT && (!ov_reg || !out_stall))
        begin
            ores_reg <= res_reg;
            ohit_reg <= hit_reg;
        end
    end

    fbab_ram #(.WIDTH(32), .DEPTH(Depth)) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_wa),
        .wdata (mem_wd),
        .raddr (mem_ra),
        .rdata (mem_rd)
    );

    fbab_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    assign out_valid = ov_reg;
    assign out_red   = ores_reg[7:0];
    assign out_green = ores_reg[15:8];
    assign out_blue  = ores_reg[23:16];
    assign out_alpha = ores_reg[31:24];
    assign in_range  = ohit_reg;

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> in_stall) else $error("word taken while busy");
    a_write_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> state_reg != ST_IDLE) else $error("store written while idle");
    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ov_reg) |-> $past(state_reg) == ST_OUT) else $error("stray result word");
    a_mix_sum: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MIX |-> mix_sum <= 17'd65152) else $error("blend sum overflow");
endmodule

### hdl/fbab_ram.sv
module fbab_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### hdl/fbab_div.sv
module fbab_div (
    input  logic                clk,
    input  logic                rst_n,
    input  fbab_pkg::div_req_t  req,
    output fbab_pkg::div_rsp_t  rsp
);
    import fbab_pkg::*;

    // restoring divider, one quotient bit a cycle
    logic [17:0] rem_reg, rem_next;
    logic [9:0]  quo_reg, quo_next;
    logic [7:0]  den_reg, den_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [17:0] trial;
    logic [17:0] part;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        part  = rem_reg >> cnt_reg;
        trial = {10'd0, den_reg};
        if (req.start)
        begin
            rem_next  = req.num;
            den_next  = req.den;
            quo_next  = '0;
            cnt_next  = 5'd9;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[8:0], 1'b0};
            if (part >= trial)
            begin
                quo_next[0] = 1'b1;
                rem_next = rem_reg - (trial << cnt_reg);
            end
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 5'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg) else $error("divider done held");
    a_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |=> busy_reg) else $error("divider did not start");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg)) else $error("done without busy");
endmodule

### tb/tb_framebuffer_alpha_blend_engine_unit.sv
module tb_framebuffer_alpha_blend_engine_unit;
    import fbab_pkg::*;

    // one expected result word
    typedef struct {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
        logic       hit;
    } pixel_word_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic               cfg_index;
    logic [7:0]         cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         func;
    logic signed [10:0] pos_x;
    logic signed [10:0] pos_y;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         coverage;
    logic               out_valid;
    logic               out_stall;
    logic [7:0]         out_red;
    logic [7:0]         out_green;
    logic [7:0]         out_blue;
    logic [7:0]         out_alpha;
    logic               in_range;

    framebuffer_alpha_blend_engine_unit dut (.*);

    // shadow framebuffer and frame size registers
    logic [31:0]  shadow_fb [0:Depth-1];
    logic [7:0]   shadow_width;
    logic [7:0]   shadow_height;
    pixel_word_t  pending_pixels [$];
    int           fail_count;
    int           send_idle_pct;
    int           recv_stall_pct;
    int           hold_request;
    int           hold_left;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // generous upper bound, slowest run is well under a tenth of this
    initial
    begin
        #80_000_000;
        $display("framebuffer_alpha_blend_engine_unit: mismatch");
        $finish;
    end

    function automatic int clamp_dim(input logic [7:0] v, input int lim);
        return (int'(v) > lim) ? lim : int'(v);
    endfunction

    function automatic logic [7:0] blend_channel(input int c, input int old, input int cv);
        return 8'((c * cv + old * (255 - cv) + 127) / 255);
    endfunction

    // apply one accepted word to the shadow store, return the result word
    function automatic pixel_word_t model_word(input logic [1:0] f, input int px, input int py,
                                               input logic [7:0] r, input logic [7:0] g,
                                               input logic [7:0] b, input logic [7:0] cv);
        pixel_word_t res;
        int          w;
        int          h;
        int          lx;
        int          ly;
        int          idx;
        logic [31:0] p;
        res = '{8'd0, 8'd0, 8'd0, 8'd0, 1'b0};
        w = clamp_dim(shadow_width, MaxWidth);
        h = clamp_dim(shadow_height, MaxHeight);
        if (f == FUNC_BLEND || f == FUNC_READ)
        begin
            if (px >= 0 && py >= 0 && px < w && py < h)
            begin
                idx = py * MaxWidth + px;
                p = shadow_fb[idx];
                res.hit = 1'b1;
                if (f == FUNC_READ)
                begin
                    res.r = p[7:0];
                    res.g = p[15:8];
                    res.b = p[23:16];
                    res.a = p[31:24];
                end
                else
                    shadow_fb[idx] = {p[31:24], blend_channel(b, p[23:16], cv),
                                      blend_channel(g, p[15:8], cv),
                                      blend_channel(r, p[7:0], cv)};
            end
        end
        else if (f == FUNC_FILL)
        begin
            for (int y = 0; y < h; y++)
                for (int x = 0; x < w; x++)
                    shadow_fb[y * MaxWidth + x] = {8'd255, b, g, r};
        end
        else
        begin
            lx = (w > 1) ? w - 1 : 1;
            ly = (h > 1) ? h - 1 : 1;
            for (int y = 0; y < h; y++)
                for (int x = 0; x < w; x++)
                    shadow_fb[y * MaxWidth + x] =
                        {8'd255, ((((x / 32) + (y / 32)) % 2) == 0) ? 8'd200 : 8'd40,
                         8'(y * 255 / ly), 8'(x * 255 / lx)};
        end
        return res;
    endfunction

    // receiver: random stall, or a long hold-off when one is asked for
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (hold_request != 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // result checker, compares each word taken with the oldest expectation
    always @(posedge clk)
    begin
        pixel_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_pixels.size() == 0)
            begin
                $error("result word with nothing expected");
                fail_count++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (out_red !== want.r)
                begin
                    $error("out_red expected %0d got %0d", want.r, out_red);
                    fail_count++;
                end
                if (out_green !== want.g)
                begin
                    $error("out_green expected %0d got %0d", want.g, out_green);
                    fail_count++;
                end
                if (out_blue !== want.b)
                begin
                    $error("out_blue expected %0d got %0d", want.b, out_blue);
                    fail_count++;
                end
                if (out_alpha !== want.a)
                begin
                    $error("out_alpha expected %0d got %0d", want.a, out_alpha);
                    fail_count++;
                end
                if (in_range !== want.hit)
                begin
                    $error("in_range expected %0d got %0d", want.hit, in_range);
                    fail_count++;
                end
            end
        end
    end

    // offer one word, hold it until taken, then maybe go idle
    task automatic send_word(input logic [1:0] f, input int px, input int py,
                             input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b, input logic [7:0] cv);
        in_valid <= 1'b1;
        func     <= f;
        pos_x    <= 11'(px);
        pos_y    <= 11'(py);
        red      <= r;
        green    <= g;
        blue     <= b;
        coverage <= cv;
        do
            @(posedge clk);
        while (in_stall);
        pending_pixels.push_back(model_word(f, int'(11'sd0 + $signed(11'(px))),
                                            int'($signed(11'(py))), r, g, b, cv));
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // stop offering and wait until every expected word has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_frame_reg(input logic idx, input logic [7:0] v);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_WIDTH)
            shadow_width = v;
        else
            shadow_height = v;
    endtask

    task automatic set_frame(input logic [7:0] w, input logic [7:0] h);
        write_frame_reg(REG_WIDTH, w);
        write_frame_reg(REG_HEIGHT, h);
    endtask

    // one random word; fill and pattern kept rare so large frames stay quick
    task automatic send_random_word(input int walk_pct);
        logic [1:0] f;
        int         px;
        int         py;
        int         w;
        int         h;
        logic [7:0] cv;
        w = clamp_dim(shadow_width, MaxWidth);
        h = clamp_dim(shadow_height, MaxHeight);
        if ($urandom_range(0, 99) < walk_pct)
            f = $urandom_range(0, 1) ? FUNC_FILL : FUNC_PATTERN;
        else
            f = $urandom_range(0, 1) ? FUNC_READ : FUNC_BLEND;
        if (w > 0 && h > 0 && $urandom_range(0, 99) < 85)
        begin
            px = $urandom_range(0, w - 1);
            py = $urandom_range(0, h - 1);
        end
        else
        begin
            px = int'($signed(11'($urandom_range(0, 2047))));
            py = int'($signed(11'($urandom_range(0, 2047))));
        end
        case ($urandom_range(0, 9))
            0:       cv = 8'd0;
            1:       cv = 8'd255;
            default: cv = 8'($urandom);
        endcase
        send_word(f, px, py, 8'($urandom), 8'($urandom), 8'($urandom), cv);
    endtask

    // corners of the fields, every operation, out-of-frame and empty frame
    task automatic test_directed();
        set_frame(8'd4, 8'd3);
        send_word(FUNC_READ, 0, 0, 8'd0, 8'd0, 8'd0, 8'd0);
        send_word(FUNC_BLEND, 3, 2, 8'd255, 8'd128, 8'd1, 8'd255);
        send_word(FUNC_BLEND, 3, 2, 8'd0, 8'd0, 8'd0, 8'd0);
        send_word(FUNC_BLEND, 3, 2, 8'd0, 8'd255, 8'd77, 8'd128);
        send_word(FUNC_READ, 3, 2, 8'd0, 8'd0, 8'd0, 8'd0);
        send_word(FUNC_READ, 4, 0, 8'd0, 8'd0, 8'd0, 8'd0);
        send_word(FUNC_READ, 0, 3, 8'd0, 8'd0, 8'd0, 8'd0);
        send_word(FUNC_READ, -1, 0, 8'd0, 8'd0, 8'd0, 8'd0);
        send_word(FUNC_BLEND, -1024, 1023, 8'd255, 8'd255, 8'd255, 8'd255);
        send_word(FUNC_FILL, 0, 0, 8'd10, 8'd20, 8'd30, 8'd0);
        send_word(FUNC_BLEND, 1, 1, 8'd250, 8'd5, 8'd128, 8'd100);
        send_word(FUNC_READ, 1, 1, 8'd0, 8'd0, 8'd0, 8'd0);
        send_word(FUNC_PATTERN, 0, 0, 8'd0, 8'd0, 8'd0, 8'd0);
        send_word(FUNC_READ, 3, 2, 8'd0, 8'd0, 8'd0, 8'd0);
        // shrink: old pixels outside the frame must survive a later grow
        set_frame(8'd1, 8'd1);
        send_word(FUNC_PATTERN, 0, 0, 8'd0, 8'd0, 8'd0, 8'd0);
        send_word(FUNC_FILL, 0, 0, 8'd1, 8'd2, 8'd3, 8'd0);
        set_frame(8'd4, 8'd3);
        send_word(FUNC_READ, 2, 1, 8'd0, 8'd0, 8'd0, 8'd0);
        // empty frame: walks change nothing, everything is out of range
        set_frame(8'd0, 8'd3);
        send_word(FUNC_FILL, 0, 0, 8'd99, 8'd99, 8'd99, 8'd0);
        send_word(FUNC_READ, 0, 0, 8'd0, 8'd0, 8'd0, 8'd0);
        // oversized registers saturate to the full store
        set_frame(8'd255, 8'd255);
        send_word(FUNC_PATTERN, 0, 0, 8'd0, 8'd0, 8'd0, 8'd0);
        send_word(FUNC_READ, 127, 127, 8'd0, 8'd0, 8'd0, 8'd0);
        send_word(FUNC_READ, 128, 5, 8'd0, 8'd0, 8'd0, 8'd0);
        send_word(FUNC_READ, 40, 33, 8'd0, 8'd0, 8'd0, 8'd0);
        send_word(FUNC_BLEND, 1023, -1024, 8'd0, 8'd0, 8'd0, 8'd0);
    endtask

    task automatic run_random(input logic [7:0] w, input logic [7:0] h, input int n,
                              input int walk_pct);
        set_frame(w, h);
        repeat (n) send_random_word(walk_pct);
    endtask

    // random words under each idling pattern and a spread of frame sizes
    task automatic test_random();
        int idle_pats [4][2] = '{'{0, 0}, '{76, 0}, '{0, 76}, '{12, 12}};
        for (int i = 0; i < 4; i++)
        begin
            send_idle_pct  = idle_pats[i][0];
            recv_stall_pct = idle_pats[i][1];
            run_random(8'd1, 8'd1, 30, 5);
            run_random(8'd12, 8'd9, 120, 4);
            run_random(8'd0, 8'd5, 10, 10);
            run_random(8'd40, 8'd3, 60, 3);
            run_random(8'd128, 8'd128, 80, 0);
            run_random(8'd200, 8'd2, 30, 4);
        end
        send_idle_pct  = 12;
        recv_stall_pct = 12;
    endtask

    // receiver holds off for a long stretch while words keep coming
    task automatic test_backpressure();
        set_frame(8'd16, 8'd16);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 300;
        repeat (40) send_random_word(0);
        drain_results();
        // sender pauses until all words are back, then carries on
        repeat (20) send_random_word(2);
        drain_results();
        repeat (20) send_random_word(2);
    endtask

    initial
    begin
        for (int i = 0; i < Depth; i++)
            shadow_fb[i] = 32'd0;
        shadow_width   = 8'd0;
        shadow_height  = 8'd0;
        fail_count     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 0;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_WIDTH;
        cfg_data       = 8'd0;
        in_valid       = 1'b0;
        func           = FUNC_READ;
        pos_x          = 11'sd0;
        pos_y          = 11'sd0;
        red            = 8'd0;
        green          = 8'd0;
        blue           = 8'd0;
        coverage       = 8'd0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random();
        test_backpressure();
        drain_results();
        repeat (100) @(posedge clk);

        if (fail_count == 0)
            $display("framebuffer_alpha_blend_engine_unit: match");
        else
            $display("framebuffer_alpha_blend_engine_unit: mismatch");
        $finish;
    end
endmodule

### framebuffer_alpha_blend_engine_unit.f
hdl/fbab_pkg.sv
hdl/fbab_ram.sv
hdl/fbab_div.sv
hdl/framebuffer_alpha_blend_engine_unit.sv
tb/tb_framebuffer_alpha_blend_engine_unit.sv
